>>> design/u16u8_pkg.sv
package u16u8_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTES = 1'b1;

    // Largest code point is 0x10FFFF.
    localparam int CP_W = 21;

    // One input beat: a raw stream byte and its end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_beat;

    // One output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       error;
    } t_out_beat;

    // Work handed from the front end to the back end. A job is either an
    // error item, or zero to four UTF-8 bytes of one code point optionally
    // followed by the terminator.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      n_bytes;
        logic            term;
        logic            err;
    } t_job;

endpackage

>>> design/u16u8_front.sv
module u16u8_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [u16u8_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [u16u8_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  u16u8_pkg::t_in_beat              i_in_beat,
    input  logic                             i_full,
    output logic                             o_push,
    output u16u8_pkg::t_job                  o_job
);
    import u16u8_pkg::*;

    // Surrogate tags in the top six bits of a code unit.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    logic       r_big_endian, n_big_endian;
    logic [1:0] r_skip_bytes, n_skip_bytes;
    logic       r_in_stream, n_in_stream;
    logic [1:0] r_skip_left, n_skip_left;
    logic       r_odd, n_odd;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_surr, n_surr;
    logic [9:0] r_high_bits, n_high_bits;
    logic       r_error_seen, n_error_seen;

    logic            accept;
    logic            eos;
    logic [1:0]      skip_eff;
    logic [15:0]     unit;
    logic            is_high;
    logic            is_low;
    logic            fail;
    logic            job_valid;
    t_job            job;
    logic [CP_W-1:0] pair_cp;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign eos        = i_in_beat.end_of_stream;

    // The skip count is sampled from the register on the first byte of a stream.
    assign skip_eff = r_in_stream ? r_skip_left : r_skip_bytes;
    assign unit     = r_big_endian ? {r_held_byte, i_in_beat.data_byte}
                                   : {i_in_beat.data_byte, r_held_byte};
    assign is_high  = (unit[15:10] == SURR_HIGH_TAG);
    assign is_low   = (unit[15:10] == SURR_LOW_TAG);
    assign pair_cp  = CP_W'(21'h10000) + CP_W'({r_high_bits, unit[9:0]});

    always_comb begin
        n_big_endian = r_big_endian;
        n_skip_bytes = r_skip_bytes;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIG_ENDIAN: n_big_endian = i_cfg_data[0];
                CFG_SKIP_BYTES: n_skip_bytes = i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_in_stream  = r_in_stream;
        n_skip_left  = r_skip_left;
        n_odd        = r_odd;
        n_held_byte  = r_held_byte;
        n_surr       = r_surr;
        n_high_bits  = r_high_bits;
        n_error_seen = r_error_seen;
        fail         = 1'b0;
        job_valid    = 1'b0;
        job          = '0;
        if (accept) begin
            n_in_stream = 1'b1;
            n_skip_left = skip_eff;
            if (r_error_seen) begin
                // Bytes are swallowed until the end marker.
            end else if (skip_eff != 2'd0) begin
                n_skip_left = skip_eff - 2'd1;
                if (eos) begin
                    if (n_skip_left != 2'd0) begin
                        fail = 1'b1;
                    end else begin
                        job_valid = 1'b1;
                        job.term  = 1'b1;
                    end
                end
            end else if (!r_odd) begin
                n_held_byte = i_in_beat.data_byte;
                n_odd       = 1'b1;
                fail        = eos;
            end else begin
                n_odd = 1'b0;
                if (r_surr) begin
                    if (!is_low) begin
                        fail = 1'b1;
                    end else begin
                        job_valid   = 1'b1;
                        job.cp      = pair_cp;
                        job.n_bytes = 3'd4;
                        job.term    = eos;
                        n_surr      = 1'b0;
                        n_high_bits = '0;
                    end
                end else if (is_high) begin
                    n_surr      = 1'b1;
                    n_high_bits = unit[9:0];
                    fail        = eos;
                end else if (is_low) begin
                    fail = 1'b1;
                end else begin
                    job_valid = 1'b1;
                    job.cp    = CP_W'(unit);
                    job.term  = eos;
                    if (unit[15:7] == '0) begin
                        job.n_bytes = 3'd1;
                    end else if (unit[15:11] == '0) begin
                        job.n_bytes = 3'd2;
                    end else begin
                        job.n_bytes = 3'd3;
                    end
                end
            end
            if (fail) begin
                job_valid = 1'b1;
                job       = '0;
                job.err   = 1'b1;
                if (!eos) begin
                    n_error_seen = 1'b1;
                end
            end
            if (eos) begin
                n_in_stream  = 1'b0;
                n_skip_left  = '0;
                n_odd        = 1'b0;
                n_held_byte  = '0;
                n_surr       = 1'b0;
                n_high_bits  = '0;
                n_error_seen = 1'b0;
            end
        end
    end

    assign o_push = job_valid;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_skip_bytes <= '0;
            r_in_stream  <= 1'b0;
            r_skip_left  <= '0;
            r_odd        <= 1'b0;
            r_held_byte  <= '0;
            r_surr       <= 1'b0;
            r_high_bits  <= '0;
            r_error_seen <= 1'b0;
        end else begin
            r_big_endian <= n_big_endian;
            r_skip_bytes <= n_skip_bytes;
            r_in_stream  <= n_in_stream;
            r_skip_left  <= n_skip_left;
            r_odd        <= n_odd;
            r_held_byte  <= n_held_byte;
            r_surr       <= n_surr;
            r_high_bits  <= n_high_bits;
            r_error_seen <= n_error_seen;
        end
    end

endmodule

>>> design/u16u8_queue.sv
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16u8_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output u16u8_pkg::t_job o_job
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> design/u16u8_back.sv
module u16u8_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  u16u8_pkg::t_job      i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output u16u8_pkg::t_out_beat o_out_beat
);
    import u16u8_pkg::*;

    // Byte k of the n-byte UTF-8 form of a code point.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] n,
                                             input logic [2:0] k);
        logic [7:0] b;
        b = '0;
        case (n)
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (k == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (k)
                    3'd0:    b = {4'b1110, cp[15:12]};
                    3'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    3'd0:    b = {5'b11110, cp[20:18]};
                    3'd1:    b = {2'b10, cp[17:12]};
                    3'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    logic      [2:0] r_idx, n_idx;
    logic            r_out_valid, n_out_valid;
    t_out_beat       r_out_beat, n_out_beat;

    logic       load;
    logic [2:0] total_m1;
    logic       job_done;

    // A queued job loads the output register when that is empty or being drained.
    assign load     = !i_empty && (!r_out_valid || i_out_ready);
    assign total_m1 = i_job.err ? 3'd0 : (i_job.n_bytes + 3'(i_job.term) - 3'd1);
    assign job_done = (r_idx == total_m1);
    assign o_pop    = load && job_done;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = job_done ? 3'd0 : r_idx + 3'd1;
            if (i_job.err) begin
                n_out_beat = '{out_byte: 8'h00, is_last: 1'b1, error: 1'b1};
            end else if (r_idx < i_job.n_bytes) begin
                n_out_beat = '{out_byte: utf8_byte(i_job.cp, i_job.n_bytes, r_idx),
                               is_last: 1'b0, error: 1'b0};
            end else begin
                n_out_beat = '{out_byte: 8'h00, is_last: 1'b1, error: 1'b0};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/utf16_to_utf8_transcoder_top.sv
// UTF-16 to UTF-8 stream transcoder.
// The input channel (i_in_valid, o_in_ready, i_in_beat) carries one stream byte
// per beat, with end_of_stream set on the final byte. The output channel
// (o_out_valid, i_out_ready, o_out_beat) carries one UTF-8 byte per beat; the
// stream closes with a zero terminator beat marked is_last, or with a single
// error beat marked is_last and error when the input is malformed.
// Byte order and the number of leading bytes to drop are set through the
// write port (i_cfg_we, i_cfg_idx, i_cfg_data). The user must write them only
// while the block is idle; the block itself does not enforce this. The front
// end takes one input beat per cycle whenever the job queue has room, so
// back-to-back input is accepted with no bubbles. The back end sends one
// output beat per cycle while the receiver is ready; a code point takes one to
// four beats, so for three-byte characters the single output register of the
// back end limits the input rate. A byte that completes a code point pushes a job
// into the job queue; its first output beat then goes to the output register.
// Synchronous reset clears the stream state, empties the queue and drops
// the output register; both configuration registers return to zero.
// When the receiver stalls, the output beat holds, the queue fills, and
// o_in_ready falls once QUEUE_DEPTH jobs are waiting.
module utf16_to_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [u16u8_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [u16u8_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  u16u8_pkg::t_in_beat              i_in_beat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output u16u8_pkg::t_out_beat             o_out_beat
);
    import u16u8_pkg::*;

    // Jobs flow from the classifier through the queue to the serializer.
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job push_job;
    t_job head_job;

    // The front end tracks the stream state, pairs bytes into code units,
    // resolves surrogates and decides how many bytes each code point needs.
    u16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // The queue lets the front end keep taking bytes while the back end is
    // still busy with a multi-byte character or a stalled receiver.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    // The back end turns each job into its UTF-8 bytes, terminator or error
    // beat, one per cycle unless stalled, through a registered output stage.
    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

>>> tb/utf16_to_utf8_checker.sv
module utf16_to_utf8_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [u16u8_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [u16u8_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  u16u8_pkg::t_in_beat              i_in_beat,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  u16u8_pkg::t_out_beat             i_out_beat,
    output int                               o_failures,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    // Shadow copy of the configuration registers.
    logic       big_endian;
    logic [1:0] skip_bytes;

    // Shadow copy of the stream state.
    logic       in_stream;
    logic [1:0] skip_left;
    logic       odd_phase;
    logic [7:0] held_byte;
    logic       surrogate_pending;
    logic [9:0] high_bits;
    logic       error_seen;

    // UTF-8 beats that the block still owes, oldest first.
    t_out_beat utf8_due[$];

    function automatic void clear_stream();
        in_stream         = 1'b0;
        skip_left         = 2'd0;
        odd_phase         = 1'b0;
        held_byte         = 8'd0;
        surrogate_pending = 1'b0;
        high_bits         = 10'd0;
        error_seen        = 1'b0;
    endfunction

    function automatic void owe_beat(input logic [7:0] b, input logic last, input logic err);
        t_out_beat due_beat;
        due_beat.out_byte = b;
        due_beat.is_last  = last;
        due_beat.error    = err;
        utf8_due.push_back(due_beat);
    endfunction

    // An error closes the stream at once when it falls on the final byte;
    // otherwise the rest of the stream is swallowed.
    function automatic void owe_error(input logic eos);
        owe_beat(8'd0, 1'b1, 1'b1);
        if (eos) begin
            clear_stream();
        end else begin
            error_seen = 1'b1;
        end
    endfunction

    function automatic void owe_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            owe_beat(cp[7:0], 1'b0, 1'b0);
        end else if (cp <= 21'h7FF) begin
            owe_beat({3'b110, cp[10:6]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
        end else if (cp <= 21'hFFFF) begin
            owe_beat({4'b1110, cp[15:12]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
        end else begin
            owe_beat({5'b11110, cp[20:18]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[17:12]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
            owe_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
        end
    endfunction

    // Advances the shadow state by one stream byte and queues what it yields.
    // High surrogates carry 110110 in their top six bits, low ones 110111.
    function automatic void predict_utf8(input logic [7:0] b, input logic eos);
        logic [15:0] code_unit;
        if (!in_stream) begin
            in_stream = 1'b1;
            skip_left = skip_bytes;
        end
        if (error_seen) begin
            if (eos) begin
                clear_stream();
            end
            return;
        end
        if (skip_left != 2'd0) begin
            skip_left = skip_left - 2'd1;
            if (eos) begin
                if (skip_left != 2'd0) begin
                    owe_error(1'b1);
                end else begin
                    owe_beat(8'd0, 1'b1, 1'b0);
                    clear_stream();
                end
            end
            return;
        end
        if (!odd_phase) begin
            held_byte = b;
            odd_phase = 1'b1;
            if (eos) begin
                owe_error(1'b1);
            end
            return;
        end
        odd_phase = 1'b0;
        code_unit = big_endian ? {held_byte, b} : {b, held_byte};
        if (surrogate_pending) begin
            if (code_unit[15:10] != 6'b110111) begin
                owe_error(eos);
                return;
            end
            surrogate_pending = 1'b0;
            owe_utf8(21'h10000 + {1'b0, high_bits, code_unit[9:0]});
            high_bits = 10'd0;
        end else if (code_unit[15:10] == 6'b110110) begin
            surrogate_pending = 1'b1;
            high_bits         = code_unit[9:0];
            if (eos) begin
                owe_error(eos);
                return;
            end
        end else if (code_unit[15:10] == 6'b110111) begin
            owe_error(eos);
            return;
        end else begin
            owe_utf8({5'd0, code_unit});
        end
        if (eos) begin
            owe_beat(8'd0, 1'b1, 1'b0);
            clear_stream();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat due_beat;
        if (!i_rst_n) begin
            big_endian = 1'b0;
            skip_bytes = 2'd0;
            clear_stream();
            utf8_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIG_ENDIAN: big_endian = i_cfg_data[0];
                    CFG_SKIP_BYTES: skip_bytes = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_utf8(i_in_beat.data_byte, i_in_beat.end_of_stream);
            end
            if (i_out_valid && i_out_ready) begin
                if (utf8_due.size() == 0) begin
                    o_failures++;
                    $display("%0t: expected no beat, got byte %02h last %0b error %0b",
                             $time, i_out_beat.out_byte, i_out_beat.is_last,
                             i_out_beat.error);
                end else begin
                    due_beat = utf8_due.pop_front();
                    if (i_out_beat.out_byte !== due_beat.out_byte ||
                        i_out_beat.is_last !== due_beat.is_last ||
                        i_out_beat.error !== due_beat.error) begin
                        o_failures++;
                        $display("%0t: expected byte %02h last %0b error %0b, ",
                                 $time, due_beat.out_byte, due_beat.is_last,
                                 due_beat.error,
                                 "got byte %02h last %0b error %0b",
                                 i_out_beat.out_byte, i_out_beat.is_last,
                                 i_out_beat.error);
                    end
                end
            end
        end
        o_outstanding <= utf8_due.size();
    end

endmodule

>>> tb/utf16_to_utf8_transcoder_top_test.sv
module utf16_to_utf8_transcoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_BYTES  = 420;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 500000;

    // Shapes of a random stream. Everything but the well-formed and noise kinds
    // ends in an error beat, except a stream that holds only its skipped prefix.
    typedef enum int {
        WELL_FORMED,
        ODD_LENGTH,
        LONE_LOW,
        BROKEN_PAIR,
        HIGH_AT_END,
        SHORT_OF_SKIP,
        SKIP_ONLY,
        NOISE
    } t_stream_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_beat              i_in_beat;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;

    // When set, neither side inserts gaps or stalls for the current phase.
    bit no_idle = 1'b0;

    // The configuration as last written, so streams can be built to match it.
    logic       cur_big_endian;
    logic [1:0] cur_skip;

    // Bytes of the stream under construction, in wire order.
    logic [7:0] stream_bytes[$];

    utf16_to_utf8_transcoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    utf16_to_utf8_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_beat   (o_out_beat),
        .o_failures   (failures),
        .o_outstanding(outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog. A correct run finishes far below this bound even with every
    // beat hit by the longest stalls on both sides.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver. It stalls at random, a few stalls run much longer, and
    // phases with no_idle set keep the output drained at full rate.
    always @(posedge i_clk) begin : receiver
        int unsigned roll;
        if (!i_rst_n || no_idle) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                stall_left <= $urandom_range(1, 3);
            end else if (roll < 24) begin
                stall_left <= $urandom_range(8, 40);
            end
        end
    end

    // Presents one beat and holds it until the block takes it. Valid stays up
    // when no gap follows, so back-to-back beats never drop valid in between.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int          gap;
        int unsigned roll;
        i_in_valid <= 1'b1;
        i_in_beat  <= '{data_byte: b, end_of_stream: eos};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) begin
            gap = 0;
        end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(6, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends the assembled stream with the end marker on its final byte.
    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        stream_bytes.delete();
    endtask

    // Lets the block run dry: waits until every owed beat has arrived, then lets
    // any byte that yields nothing but may still be in flight settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only called while idle.
    task automatic set_mode(input logic be, input logic [1:0] skip);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BIG_ENDIAN;
        i_cfg_data <= {1'b0, be};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SKIP_BYTES;
        i_cfg_data <= skip;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_big_endian = be;
        cur_skip       = skip;
    endtask

    function automatic void push_unit(input logic [15:0] code_unit);
        if (cur_big_endian) begin
            stream_bytes.push_back(code_unit[15:8]);
            stream_bytes.push_back(code_unit[7:0]);
        end else begin
            stream_bytes.push_back(code_unit[7:0]);
            stream_bytes.push_back(code_unit[15:8]);
        end
    endfunction

    // Code points above the basic plane go out as a surrogate pair.
    function automatic void push_code_point(input logic [20:0] cp);
        logic [19:0] offset;
        offset = 20'(cp - 21'h10000);
        if (cp > 21'hFFFF) begin
            push_unit({6'b110110, offset[19:10]});
            push_unit({6'b110111, offset[9:0]});
        end else begin
            push_unit(cp[15:0]);
        end
    endfunction

    // A basic-plane unit that is not a surrogate, spread over the 1, 2 and
    // 3 byte encodings, with the range limits drawn often.
    function automatic logic [15:0] random_bmp();
        logic [15:0] bmp_limits[8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                       16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: return bmp_limits[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [20:0] random_code_point();
        if ($urandom_range(0, 3) == 0) begin
            return 21'($urandom_range(21'h10000, 21'h10FFFF));
        end
        return {5'd0, random_bmp()};
    endfunction

    initial begin : stimulus
        t_stream_kind kind;
        int unsigned  roll;
        int           sent_bytes;
        int           streams_left;
        int           counted;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BIG_ENDIAN;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_beat  <= '0;
        cur_big_endian = 1'b0;
        cur_skip       = 2'd0;
        sent_bytes     = 0;
        streams_left   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first under the reset configuration: little endian
        // with nothing skipped. One stream walks the edges of every UTF-8
        // length, including the first and last supplementary code points.
        push_code_point(21'h000000);
        push_code_point(21'h00007F);
        push_code_point(21'h000080);
        push_code_point(21'h0007FF);
        push_code_point(21'h000800);
        push_code_point(21'h00FFFF);
        push_code_point(21'h010000);
        push_code_point(21'h10FFFF);
        send_stream();

        // A lone low surrogate in mid stream; the byte after it is dropped.
        push_unit(16'hDC00);
        stream_bytes.push_back(8'hFF);
        send_stream();
        drain();

        // Big endian with the widest skip: a stream that ends inside the
        // skipped prefix fails, one exactly as long as the prefix only closes.
        set_mode(1'b1, 2'd3);
        stream_bytes.push_back(8'hFE);
        stream_bytes.push_back(8'hFF);
        send_stream();
        stream_bytes.push_back(8'hFE);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h00);
        send_stream();

        // Random part, in phases of a few streams under one configuration.
        // Most streams are well formed so that surrogate pairs and all UTF-8
        // lengths get exercised; the rest are noise, a bare prefix, or one malformation.
        while (sent_bytes < RANDOM_BYTES) begin
            if (streams_left == 0) begin
                drain();
                set_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                no_idle <= ($urandom_range(0, 5) == 0);
                streams_left = $urandom_range(3, 10);
            end
            streams_left--;

            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                kind = WELL_FORMED;
            end else if (roll < 66) begin
                kind = ODD_LENGTH;
            end else if (roll < 71) begin
                kind = LONE_LOW;
            end else if (roll < 77) begin
                kind = BROKEN_PAIR;
            end else if (roll < 82) begin
                kind = HIGH_AT_END;
            end else if (roll < 87) begin
                kind = SHORT_OF_SKIP;
            end else if (roll < 91) begin
                kind = SKIP_ONLY;
            end else begin
                kind = NOISE;
            end
            // A prefix must exist to end inside it or to consist of it alone.
            if ((kind == SHORT_OF_SKIP && cur_skip < 2'd2) ||
                (kind == SKIP_ONLY && cur_skip == 2'd0)) begin
                kind = WELL_FORMED;
            end

            if (kind == NOISE) begin
                repeat ($urandom_range(1, 9)) stream_bytes.push_back(8'($urandom));
            end else if (kind == SHORT_OF_SKIP) begin
                repeat ($urandom_range(1, cur_skip - 1)) begin
                    stream_bytes.push_back(8'($urandom));
                end
            end else begin
                repeat (cur_skip) stream_bytes.push_back(8'($urandom));
                if (kind != SKIP_ONLY) begin
                    repeat ($urandom_range(kind == WELL_FORMED ? 1 : 0, 5)) begin
                        push_code_point(random_code_point());
                    end
                end
                case (kind)
                    ODD_LENGTH: stream_bytes.push_back(8'($urandom));
                    LONE_LOW: push_unit({6'b110111, 10'($urandom)});
                    BROKEN_PAIR: begin
                        // The partner is either an ordinary unit or another
                        // high surrogate; neither completes the pair.
                        push_unit({6'b110110, 10'($urandom)});
                        if ($urandom_range(0, 3) == 0) begin
                            push_unit({6'b110110, 10'($urandom)});
                        end else begin
                            push_unit(random_bmp());
                        end
                    end
                    HIGH_AT_END: push_unit({6'b110110, 10'($urandom)});
                    default: ;
                endcase
            end

            // Bytes after a mid-stream error are ignored by the block, so
            // they are not counted as stimulus.
            counted = stream_bytes.size();
            if (kind == LONE_LOW || kind == BROKEN_PAIR) begin
                repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom));
            end
            sent_bytes += counted;
            send_stream();
        end

        drain();
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
